@@ rtl/cie_pkg.sv @@
`timescale 1ns / 1ps

package cie_pkg;

  localparam logic [15:0] HALT_WORD  = 16'hFFFF;
  localparam logic [15:0] STACK_BASE = 16'h8200;

  // opcodes, bits 15-12 of the instruction word
  localparam logic [3:0] OP_SYS = 4'd0;
  localparam logic [3:0] OP_MOV = 4'd1;
  localparam logic [3:0] OP_STR = 4'd2;
  localparam logic [3:0] OP_LDR = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_SUB = 4'd5;
  localparam logic [3:0] OP_MUL = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_ORR = 4'd8;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_XOR = 4'd10;
  localparam logic [3:0] OP_SHR = 4'd11;
  localparam logic [3:0] OP_SHL = 4'd12;
  localparam logic [3:0] OP_ROR = 4'd13;
  localparam logic [3:0] OP_ROL = 4'd14;

  // low two bits of an OP_SYS word without the immediate bit
  localparam logic [1:0] SYS_NONE = 2'd0;
  localparam logic [1:0] SYS_PUSH = 2'd1;
  localparam logic [1:0] SYS_POP  = 2'd2;
  localparam logic [1:0] SYS_CMP  = 2'd3;

  // low two bits of an OP_SYS word with the immediate bit (jump conditions)
  localparam logic [1:0] JMP_ALWAYS = 2'd0;
  localparam logic [1:0] JMP_EQ     = 2'd1;
  localparam logic [1:0] JMP_NEG    = 2'd2;
  localparam logic [1:0] JMP_POS    = 2'd3;

  // positions in the flag word
  localparam int FLAG_C = 0;
  localparam int FLAG_V = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_S = 3;

  typedef logic [3:0] flags_t;

  typedef struct packed {
    logic [15:0] value;
    flags_t      flags;
  } alu_res_t;

  typedef enum logic [1:0] {
    SRC_ALU,
    SRC_DMEM,
    SRC_STACK
  } src_t;

endpackage

@@ rtl/cie_ram.sv @@
`timescale 1ns / 1ps

module cie_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cie_alu.sv @@
`timescale 1ns / 1ps

module cie_alu
  import cie_pkg::*;
(
  input  logic [3:0]  op,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output alu_res_t    res
);

  logic [16:0] sum;
  logic [15:0] diff;
  logic [15:0] prod;
  logic [15:0] value;
  logic        carry;
  logic        ovf;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = a - b;
  assign prod = a * b;

  always_comb begin
    carry = 1'b0;
    ovf   = 1'b0;
    unique case (op)
      OP_ADD: begin
        value = sum[15:0];
        carry = sum[16];
        ovf   = ~(a[15] ^ b[15]) & (a[15] ^ sum[15]);
      end
      OP_SUB: begin
        value = diff;
        carry = a < b;
        ovf   = (a[15] ^ b[15]) & (a[15] ^ diff[15]);
      end
      // compare: borrow only, overflow stays clear
      OP_SYS: begin
        value = diff;
        carry = a < b;
      end
      OP_MUL: value = prod;
      OP_AND: value = a & b;
      OP_ORR: value = a | b;
      OP_NOT: value = ~a;
      OP_XOR: value = a ^ b;
      OP_SHR: value = {1'b0, a[15:1]};
      OP_SHL: value = {a[14:0], 1'b0};
      OP_ROR: value = {a[0], a[15:1]};
      OP_ROL: value = {a[14:0], a[15]};
      default: value = '0;
    endcase
  end

  always_comb begin
    res.value          = value;
    res.flags          = '0;
    res.flags[FLAG_C]  = carry;
    res.flags[FLAG_V]  = ovf;
    res.flags[FLAG_Z]  = (value == 16'd0);
    res.flags[FLAG_S]  = value[15];
  end

endmodule

@@ rtl/cpu16_instruction_execute.sv @@
`timescale 1ns / 1ps

// channel      | dir | handshake                         | words
// instruction  | in  | instruction_valid/_ready          | instruction[15:0]
// result       | out | result_valid/_ready               | next_pc, halted, flag_bits,
//              |     |                                   | dump_strobe, stack_fault,
//              |     |                                   | reg_written, reg_number, reg_result
//
// one instruction per cycle sustained while results are taken; a taken word passes the
// register file read, then execute, then the output stage that also writes back.
// ldr and pop data come straight from the data and stack memory read registers.
// rst clears pc, flags, halt, the pipeline valids and the per-register written bits, sets sp
// to STACK_BASE; memories are not cleared, a register not written since reset reads as zero.
// a stalled result holds the output stage; one more instruction waits in execute.

module cpu16_instruction_execute
  import cie_pkg::*;
#(
  parameter int STACK_WORDS = 8,
  parameter int DATA_BYTES  = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        instruction_valid,
  output logic        instruction_ready,
  input  logic [15:0] instruction,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] next_pc,
  output logic        halted,
  output logic [3:0]  flag_bits,
  output logic        dump_strobe,
  output logic        stack_fault,
  output logic        reg_written,
  output logic [2:0]  reg_number,
  output logic [15:0] reg_result
);

  localparam int SAW = $clog2(STACK_WORDS);
  localparam int DAW = $clog2(DATA_BYTES);

  // architectural state kept in flops
  logic [15:0] pc, pc_next;
  logic [15:0] sp, sp_next;
  flags_t      flags, flags_next;
  logic        halt, halt_next;

  // pipeline control
  logic accept, s1_fire;
  logic s1_valid, s1_first;
  logic s2_valid;

  // execute stage payload
  logic [15:0] s1_ir;
  logic [2:0]  s1_ra, s1_rb;
  logic [15:0] hold_a, hold_b;

  // write that landed at the edge an instruction entered execute
  logic        fw_v;
  logic [2:0]  fw_num;
  logic [15:0] fw_val;

  // output stage payload
  logic [15:0] s2_pc;
  logic        s2_halt;
  flags_t      s2_flags;
  logic        s2_dump, s2_fault, s2_wr, s2_oor;
  logic [2:0]  s2_num;
  logic [15:0] s2_val;
  src_t        s2_src;
  logic [15:0] s2_value;

  // memories
  logic [15:0] rfa_q, rfb_q, stk_q;
  logic [7:0]  dmem_q;
  logic [2:0]  rb_addr;
  logic [7:0]  rf_set;
  logic        ra_set, rb_set;

  // execute decode and results
  logic [3:0]  op;
  logic        imm;
  logic [2:0]  rd, rn;
  logic [1:0]  low2;
  logic [15:0] op_a, op_b;
  alu_res_t    alu;
  logic        ex_wr, ex_dump, ex_fault, ex_oor;
  logic [2:0]  ex_num;
  logic [15:0] ex_val;
  src_t        ex_src;
  logic        dmem_we, dmem_re, stk_we, stk_re;
  logic [15:0] sp_gap;
  logic [14:0] depth, depth_m1;
  logic        take;

  assign accept            = instruction_valid && instruction_ready;
  assign s1_fire           = s1_valid && (!s2_valid || result_ready);
  assign instruction_ready = !s1_valid || s1_fire;

  // port b serves rd for a store without the immediate bit, rm otherwise
  assign rb_addr = (instruction[15:12] == OP_STR && !instruction[11]) ?
                   instruction[10:8] : instruction[2:0];

  cie_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
    .clk   (clk),
    .we    (s2_valid && s2_wr),
    .waddr (s2_num),
    .wdata (s2_value),
    .re    (accept),
    .raddr (instruction[7:5]),
    .rdata (rfa_q)
  );

  cie_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
    .clk   (clk),
    .we    (s2_valid && s2_wr),
    .waddr (s2_num),
    .wdata (s2_value),
    .re    (accept),
    .raddr (rb_addr),
    .rdata (rfb_q)
  );

  cie_ram #(.WIDTH(16), .DEPTH(STACK_WORDS)) u_stack (
    .clk   (clk),
    .we    (s1_fire && stk_we),
    .waddr (depth[SAW-1:0]),
    .wdata (op_a),
    .re    (s1_fire && stk_re),
    .raddr (depth_m1[SAW-1:0]),
    .rdata (stk_q)
  );

  cie_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
    .clk   (clk),
    .we    (s1_fire && dmem_we),
    .waddr (op_a[DAW-1:0]),
    .wdata (op_b[7:0]),
    .re    (s1_fire && dmem_re),
    .raddr (op_b[DAW-1:0]),
    .rdata (dmem_q)
  );

  // value the output stage writes back
  always_comb begin
    unique case (s2_src)
      SRC_DMEM:  s2_value = s2_oor ? 16'd0 : {8'd0, dmem_q};
      SRC_STACK: s2_value = stk_q;
      default:   s2_value = s2_val;
    endcase
  end

  // operand forwarding: output stage first, then the held operand after entry, then the write at entry, then the read
  always_comb begin
    if (s2_valid && s2_wr && s2_num == s1_ra) begin
      op_a = s2_value;
    end else if (!s1_first) begin
      op_a = hold_a;
    end else if (fw_v && fw_num == s1_ra) begin
      op_a = fw_val;
    end else begin
      op_a = ra_set ? rfa_q : 16'd0;
    end
    if (s2_valid && s2_wr && s2_num == s1_rb) begin
      op_b = s2_value;
    end else if (!s1_first) begin
      op_b = hold_b;
    end else if (fw_v && fw_num == s1_rb) begin
      op_b = fw_val;
    end else begin
      op_b = rb_set ? rfb_q : 16'd0;
    end
  end

  assign op   = s1_ir[15:12];
  assign imm  = s1_ir[11];
  assign rd   = s1_ir[10:8];
  assign rn   = s1_ir[7:5];
  assign low2 = s1_ir[1:0];

  cie_alu u_alu (
    .op  (op),
    .a   (op_a),
    .b   (op_b),
    .res (alu)
  );

  assign sp_gap   = STACK_BASE - sp;
  assign depth    = sp_gap[15:1];
  assign depth_m1 = depth - 15'd1;

  always_comb begin
    pc_next    = pc;
    sp_next    = sp;
    flags_next = flags;
    halt_next  = halt;
    ex_wr      = 1'b0;
    ex_num     = '0;
    ex_val     = '0;
    ex_src     = SRC_ALU;
    ex_dump    = 1'b0;
    ex_fault   = 1'b0;
    ex_oor     = 1'b0;
    dmem_we    = 1'b0;
    dmem_re    = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    take       = 1'b0;
    if (!halt) begin
      pc_next = 16'(pc + 16'd2);
      if (s1_ir == HALT_WORD) begin
        halt_next = 1'b1;
      end else begin
        ex_dump = (s1_ir == 16'd0);
        unique case (op)
          OP_MOV: begin
            ex_wr  = 1'b1;
            ex_num = rd;
            ex_val = imm ? {8'd0, s1_ir[7:0]} : op_b;
          end
          OP_STR: begin
            if (imm) begin
              ex_wr  = 1'b1;
              ex_num = rn;
              ex_val = {8'd0, s1_ir[7:0]};
            end else begin
              dmem_we = ({1'b0, op_a} < 17'(DATA_BYTES));
            end
          end
          OP_LDR: begin
            ex_wr   = 1'b1;
            ex_num  = rd;
            ex_src  = SRC_DMEM;
            ex_oor  = !({1'b0, op_b} < 17'(DATA_BYTES));
            dmem_re = 1'b1;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_ORR, OP_NOT, OP_XOR, OP_SHR, OP_SHL: begin
            ex_wr      = 1'b1;
            ex_num     = rd;
            ex_val     = alu.value;
            flags_next = alu.flags;
          end
          OP_ROR, OP_ROL: begin
            ex_wr  = 1'b1;
            ex_num = rd;
            ex_val = alu.value;
          end
          OP_SYS: begin
            if (low2 == SYS_CMP) begin
              flags_next = alu.flags;
            end
            if (imm) begin
              // compare-and-jump tests the flags it has just set
              unique case (low2)
                JMP_ALWAYS: take = 1'b1;
                JMP_EQ:     take = flags_next[FLAG_Z] && !flags_next[FLAG_S];
                JMP_NEG:    take = !flags_next[FLAG_Z] && flags_next[FLAG_S];
                default:    take = !flags_next[FLAG_Z] && !flags_next[FLAG_S];
              endcase
              if (take) begin
                pc_next = 16'(pc + 16'd2 + {9'd0, s1_ir[8:2]});
              end
            end else if (low2 == SYS_PUSH) begin
              if (depth >= 15'(STACK_WORDS)) begin
                ex_fault = 1'b1;
              end else begin
                stk_we  = 1'b1;
                sp_next = 16'(sp - 16'd2);
              end
            end else if (low2 == SYS_POP) begin
              if (depth == 15'd0 || depth > 15'(STACK_WORDS)) begin
                ex_fault = 1'b1;
              end else begin
                stk_re  = 1'b1;
                sp_next = 16'(sp + 16'd2);
                ex_wr   = 1'b1;
                ex_num  = rd;
                ex_src  = SRC_STACK;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      sp       <= STACK_BASE;
      flags    <= '0;
      halt     <= 1'b0;
      s1_valid <= 1'b0;
      s1_first <= 1'b0;
      s2_valid <= 1'b0;
      fw_v     <= 1'b0;
      rf_set   <= '0;
    end else begin
      s1_first <= accept;
      if (s2_valid && s2_wr) begin
        rf_set[s2_num] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        fw_v     <= s2_valid && s2_wr;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        s2_valid <= 1'b1;
        pc       <= pc_next;
        sp       <= sp_next;
        flags    <= flags_next;
        halt     <= halt_next;
      end else if (result_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_a <= op_a;
    hold_b <= op_b;
    if (accept) begin
      s1_ir  <= instruction;
      s1_ra  <= instruction[7:5];
      s1_rb  <= rb_addr;
      ra_set <= rf_set[instruction[7:5]];
      rb_set <= rf_set[rb_addr];
      fw_num <= s2_num;
      fw_val <= s2_value;
    end
    if (s1_fire) begin
      s2_pc    <= pc_next;
      s2_halt  <= halt_next;
      s2_flags <= flags_next;
      s2_dump  <= ex_dump;
      s2_fault <= ex_fault;
      s2_wr    <= ex_wr;
      s2_num   <= ex_num;
      s2_val   <= ex_val;
      s2_src   <= ex_src;
      s2_oor   <= ex_oor;
    end
  end

  assign result_valid = s2_valid;
  assign next_pc      = s2_pc;
  assign halted       = s2_halt;
  assign flag_bits    = s2_flags;
  assign dump_strobe  = s2_dump;
  assign stack_fault  = s2_fault;
  assign reg_written  = s2_wr;
  assign reg_number   = s2_wr ? s2_num : 3'd0;
  assign reg_result   = s2_wr ? s2_value : 16'd0;

endmodule

@@ bench/tb_cpu16_instruction_execute.sv @@
`timescale 1ns / 1ps

module tb_cpu16_instruction_execute;
  import cie_pkg::*;

  localparam int STACK_DEPTH = 8;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [15:0] pc;
    logic        halt;
    logic [3:0]  flags;
    logic        dump;
    logic        fault;
    logic        wr;
    logic [2:0]  num;
    logic [15:0] val;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        instruction_valid = 1'b0;
  logic        instruction_ready;
  logic [15:0] instruction = 16'h0000;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [15:0] next_pc;
  logic        halted;
  logic [3:0]  flag_bits;
  logic        dump_strobe;
  logic        stack_fault;
  logic        reg_written;
  logic [2:0]  reg_number;
  logic [15:0] reg_result;

  // machine state as this bench sees it
  logic [15:0] gpr [0:7];
  logic [15:0] pc_model;
  logic [15:0] sp_model;
  logic [3:0]  flags_model;
  logic        halt_model;
  logic [15:0] stack_words [0:STACK_DEPTH-1];
  logic [7:0]  data_bytes [0:65535];
  bit          mem_set [0:65535];

  exec_result_t pending_results [$];
  int           fail_count = 0;
  bit           steady = 1'b0;
  int           idle_cycles = 0;

  cpu16_instruction_execute u_top (
    .clk               (clk),
    .rst               (rst),
    .instruction_valid (instruction_valid),
    .instruction_ready (instruction_ready),
    .instruction       (instruction),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .next_pc           (next_pc),
    .halted            (halted),
    .flag_bits         (flag_bits),
    .dump_strobe       (dump_strobe),
    .stack_fault       (stack_fault),
    .reg_written       (reg_written),
    .reg_number        (reg_number),
    .reg_result        (reg_result)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    return steady ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic logic [3:0] zero_sign(logic [15:0] r);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = (r == 16'h0000);
    f[FLAG_S] = r[15];
    return f;
  endfunction

  function automatic void execute_word(logic [15:0] w);
    logic [3:0]  op;
    logic        imm;
    logic [2:0]  rd, rn, rm;
    logic [1:0]  low2;
    logic [15:0] a, b, r, used;
    logic [16:0] s;
    logic [3:0]  f;
    logic        logic_op, take;
    int          depth;
    exec_result_t e;
    op = w[15:12];
    imm = w[11];
    rd = w[10:8];
    rn = w[7:5];
    rm = w[2:0];
    low2 = w[1:0];
    e = '{default: '0};
    logic_op = 1'b0;
    r = '0;
    if (!halt_model) begin
      pc_model = pc_model + 16'd2;
      if (w == HALT_WORD) begin
        halt_model = 1'b1;
      end else begin
        e.dump = (w == 16'h0000);
        a = gpr[rn];
        b = gpr[rm];
        case (op)
          OP_MOV: begin
            e.wr = 1'b1; e.num = rd; e.val = imm ? {8'h00, w[7:0]} : b;
          end
          OP_STR: begin
            if (imm) begin
              e.wr = 1'b1; e.num = rn; e.val = {8'h00, w[7:0]};
            end else begin
              data_bytes[a] = gpr[rd][7:0];
              mem_set[a] = 1'b1;
            end
          end
          OP_LDR: begin
            e.wr = 1'b1; e.num = rd; e.val = {8'h00, data_bytes[b]};
          end
          OP_ADD: begin
            s = {1'b0, a} + {1'b0, b};
            r = s[15:0];
            f = zero_sign(r);
            f[FLAG_C] = s[16];
            f[FLAG_V] = (a[15] == b[15]) && (r[15] != a[15]);
            flags_model = f;
            e.wr = 1'b1; e.num = rd; e.val = r;
          end
          OP_SUB: begin
            r = a - b;
            f = zero_sign(r);
            f[FLAG_C] = (a < b);
            f[FLAG_V] = (a[15] != b[15]) && (r[15] != a[15]);
            flags_model = f;
            e.wr = 1'b1; e.num = rd; e.val = r;
          end
          OP_MUL: begin r = a * b;        logic_op = 1'b1; end
          OP_AND: begin r = a & b;        logic_op = 1'b1; end
          OP_ORR: begin r = a | b;        logic_op = 1'b1; end
          OP_NOT: begin r = ~a;           logic_op = 1'b1; end
          OP_XOR: begin r = a ^ b;        logic_op = 1'b1; end
          OP_SHR: begin r = {1'b0, a[15:1]}; logic_op = 1'b1; end
          OP_SHL: begin r = {a[14:0], 1'b0}; logic_op = 1'b1; end
          OP_ROR: begin
            e.wr = 1'b1; e.num = rd; e.val = {a[0], a[15:1]};
          end
          OP_ROL: begin
            e.wr = 1'b1; e.num = rd; e.val = {a[14:0], a[15]};
          end
          default: ;
        endcase
        if (logic_op) begin
          flags_model = zero_sign(r);
          e.wr = 1'b1; e.num = rd; e.val = r;
        end
        if (op == OP_SYS) begin
          // compare runs first, so a compare-and-jump tests the fresh flags
          if (low2 == SYS_CMP) begin
            r = a - b;
            f = zero_sign(r);
            f[FLAG_C] = (a < b);
            flags_model = f;
          end
          used = STACK_BASE - sp_model;
          depth = int'(used[15:1]);
          if (imm) begin
            case (low2)
              JMP_ALWAYS: take = 1'b1;
              JMP_EQ:     take = flags_model[FLAG_Z] && !flags_model[FLAG_S];
              JMP_NEG:    take = !flags_model[FLAG_Z] && flags_model[FLAG_S];
              default:    take = !flags_model[FLAG_Z] && !flags_model[FLAG_S];
            endcase
            if (take) pc_model = pc_model + {9'd0, w[8:2]};
          end else if (low2 == SYS_PUSH) begin
            if (depth >= STACK_DEPTH) begin
              e.fault = 1'b1;
            end else begin
              stack_words[depth] = a;
              sp_model = sp_model - 16'd2;
            end
          end else if (low2 == SYS_POP) begin
            if (depth == 0 || depth > STACK_DEPTH) begin
              e.fault = 1'b1;
            end else begin
              sp_model = sp_model + 16'd2;
              e.wr = 1'b1; e.num = rd; e.val = stack_words[depth-1];
            end
          end
        end
        if (e.wr) gpr[e.num] = e.val;
      end
    end
    e.pc = pc_model;
    e.halt = halt_model;
    e.flags = flags_model;
    pending_results.push_back(e);
  endfunction

  function automatic logic [15:0] enc_reg(logic [3:0] op, logic [2:0] rd, logic [2:0] rn,
                                          logic [2:0] rm);
    return {op, 1'b0, rd, rn, 2'b00, rm};
  endfunction

  function automatic logic [15:0] enc_imm(logic [3:0] op, logic [2:0] rd, logic [7:0] v);
    return {op, 1'b1, rd, v};
  endfunction

  function automatic logic [15:0] enc_jump(logic [1:0] cond, logic [6:0] off);
    return {OP_SYS, 1'b1, 2'b00, off, cond};
  endfunction

  // random word that never loads from a byte nobody stored and never halts
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    logic [11:0] bits;
    int          sel, k, idx, start;
    bit          found;
    bits = 12'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 8)       w = 16'($urandom);
    else if (sel < 18) w = {OP_MOV, bits};
    else if (sel < 26) w = {OP_STR, bits};
    else if (sel < 36) w = {OP_LDR, bits};
    else if (sel < 66) w = {4'($urandom_range(OP_ADD, OP_ROL)), bits};
    else if (sel < 72) w = {OP_SYS, bits[11:2], SYS_CMP};
    else if (sel < 82) w = {OP_SYS, 1'b1, bits[10:0]};
    else if (sel < 94) w = {OP_SYS, 1'b0, bits[10:2], ($urandom_range(0, 1) ? SYS_PUSH : SYS_POP)};
    else if (sel < 96) w = 16'h0000;
    else if (sel < 98) w = {4'hF, bits};
    else               w = {OP_SYS, 1'b0, bits[10:2], SYS_NONE};
    if (w == HALT_WORD) w = 16'hFFFE;
    if (w[15:12] == OP_LDR && !mem_set[gpr[w[2:0]]]) begin
      found = 1'b0;
      start = $urandom_range(0, 7);
      for (k = 0; k < 8; k++) begin
        idx = (start + k) % 8;
        if (!found && mem_set[gpr[idx]]) begin
          w[2:0] = 3'(idx);
          found = 1'b1;
        end
      end
      // no register points at stored data yet: store instead
      if (!found) w[15:11] = {OP_STR, 1'b0};
    end
    return w;
  endfunction

  task automatic send_word(input logic [15:0] w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      instruction_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instruction_valid <= 1'b1;
    instruction <= w;
    @(posedge clk);
    while (!instruction_ready) @(posedge clk);
    execute_word(w);
  endtask

  task automatic wait_results_drained();
    instruction_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %h actual %h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic test_reset_values();
    send_word(16'h0000);
    send_word(enc_reg(OP_ADD, 3'd1, 3'd2, 3'd3));
    send_word(enc_reg(OP_SYS, 3'd2, 3'd0, {1'b0, SYS_POP}));
  endtask

  task automatic test_alu_flags();
    send_word(enc_reg(OP_NOT, 3'd2, 3'd1, 3'd0));   // ffff
    send_word(enc_reg(OP_SHR, 3'd3, 3'd2, 3'd0));   // 7fff
    send_word(enc_imm(OP_MOV, 3'd4, 8'h01));
    send_word(enc_reg(OP_ADD, 3'd5, 3'd3, 3'd4));   // signed overflow
    send_word(enc_reg(OP_ADD, 3'd6, 3'd2, 3'd4));   // carry out, zero
    send_word(enc_reg(OP_SUB, 3'd7, 3'd1, 3'd4));   // borrow
    send_word(enc_reg(OP_SUB, 3'd0, 3'd5, 3'd4));   // signed overflow
    send_word(enc_reg(OP_MUL, 3'd0, 3'd2, 3'd2));
    send_word(enc_reg(OP_SHL, 3'd1, 3'd2, 3'd0));
    send_word(enc_reg(OP_XOR, 3'd6, 3'd2, 3'd3));
    send_word(enc_reg(OP_ROR, 3'd5, 3'd4, 3'd0));
    send_word(enc_reg(OP_ROL, 3'd6, 3'd5, 3'd0));
  endtask

  task automatic test_memory_access();
    send_word(enc_reg(OP_STR, 3'd2, 3'd3, 3'd0));
    send_word(enc_reg(OP_LDR, 3'd1, 3'd0, 3'd3));
    send_word(enc_imm(OP_STR, 3'd0, 8'hA5));
    send_word(enc_reg(OP_MOV, 3'd7, 3'd0, 3'd1));
  endtask

  task automatic test_stack_and_jumps();
    send_word(enc_reg(OP_SYS, 3'd0, 3'd4, {1'b0, SYS_PUSH}));
    send_word(enc_reg(OP_SYS, 3'd0, 3'd0, {1'b0, SYS_POP}));
    send_word(enc_reg(OP_SYS, 3'd0, 3'd3, 3'd3));           // compare equal
    send_word(enc_jump(JMP_EQ, 7'h7F));
    send_word({OP_SYS, 1'b1, 3'd0, 3'd3, 2'b00, 3'd7});     // compare then jump
    send_word(enc_jump(JMP_NEG, 7'h01));
    send_word(enc_jump(JMP_ALWAYS, 7'h7F));
  endtask

  task automatic test_unused_words();
    send_word(16'hF123);
    send_word(16'h0004);
  endtask

  // push past full, then pop past empty, with random operands
  task automatic test_stack_bursts();
    int n, k;
    for (k = 0; k < STACK_DEPTH + 2; k++)
      send_word({OP_SYS, 1'b0, 9'($urandom), SYS_PUSH});
    n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 2);
    for (k = 0; k < n; k++)
      send_word({OP_SYS, 1'b0, 9'($urandom), SYS_POP});
  endtask

  task automatic test_random_program();
    int count, k, run, next_drain;
    count = 0;
    next_drain = 50;
    while (count < 360) begin
      if (count % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (count >= next_drain) begin
        wait_results_drained();
        next_drain += 100;
      end
      case ($urandom_range(0, 19))
        0: begin
          run = $urandom_range(3, 10);
          for (k = 0; k < run; k++) send_word({OP_SYS, 1'b0, 9'($urandom), SYS_PUSH});
          count += run;
        end
        1: begin
          run = $urandom_range(3, 10);
          for (k = 0; k < run; k++) send_word({OP_SYS, 1'b0, 9'($urandom), SYS_POP});
          count += run;
        end
        default: begin
          send_word(pick_word());
          count++;
        end
      endcase
    end
    steady = 1'b0;
  endtask

  // halt is sticky, so it comes last
  task automatic test_halt();
    int k;
    send_word(HALT_WORD);
    for (k = 0; k < 4; k++) send_word(16'($urandom));
  endtask

  initial begin : result_monitor
    exec_result_t e;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        compare_field("next_pc", e.pc, next_pc);
        compare_field("halted", 16'(e.halt), 16'(halted));
        compare_field("flag_bits", 16'(e.flags), 16'(flag_bits));
        compare_field("dump_strobe", 16'(e.dump), 16'(dump_strobe));
        compare_field("stack_fault", 16'(e.fault), 16'(stack_fault));
        compare_field("reg_written", 16'(e.wr), 16'(reg_written));
        compare_field("reg_number", 16'(e.num), 16'(reg_number));
        compare_field("reg_result", e.val, reg_result);
      end
    end
  end

  // no word moving on either side for too long means a hang
  always @(posedge clk) begin
    if (rst || (instruction_valid && instruction_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : main
    int k;
    for (k = 0; k < 8; k++) gpr[k] = 16'h0000;
    pc_model = 16'h0000;
    sp_model = STACK_BASE;
    flags_model = 4'h0;
    halt_model = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_alu_flags();
    test_memory_access();
    test_stack_and_jumps();
    test_unused_words();
    test_stack_bursts();
    test_random_program();
    test_halt();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ cpu16_instruction_execute.f @@
rtl/cie_pkg.sv
rtl/cie_ram.sv
rtl/cie_alu.sv
rtl/cpu16_instruction_execute.sv
bench/tb_cpu16_instruction_execute.sv
